// ----- rtl/core/api_transmit_status_frame_parser_assert.svh -----
// Assertion macros for the API transmit status frame parser.
`ifndef API_TRANSMIT_STATUS_FRAME_PARSER_ASSERT_SVH
`define API_TRANSMIT_STATUS_FRAME_PARSER_ASSERT_SVH

// implication checked in the same cycle
`define APTS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define APTS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/apts_pkg.sv -----
// Shared types and constants for the API transmit status frame parser.
package apts_pkg;

   localparam logic [7:0] START_DELIM = 8'h7E;
   localparam logic [7:0] FRAME_LEN   = 8'd7;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_TYPE,
      PH_ID,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_RETRY,
      PH_DELIV,
      PH_DISC,
      PH_CSUM
   } phase_type;

   typedef struct packed {
      logic [7:0]  frame_type;
      logic [7:0]  frame_id;
      logic [15:0] net_address;
      logic [7:0]  retry_count;
      logic [7:0]  deliv_status;
      logic [7:0]  disc_status;
      logic        checksum_ok;
   } result_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

// ----- rtl/core/apts_parse.sv -----
// Frame parser state machine: field capture, running sum and checksum compare.
module apts_parse
   import apts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] rx_byte,
   output logic       result_valid,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic        len_zero_ff, len_zero_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, id_ff, retry_ff, deliv_ff, disc_ff;
   logic [15:0] addr_ff;
   logic        data_phase;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT:    phase_in = (rx_byte == START_DELIM) ? PH_LEN_HI : PH_HUNT;
            PH_LEN_HI:  phase_in = PH_LEN_LO;
            PH_LEN_LO:  phase_in = (len_zero_ff && rx_byte == FRAME_LEN) ? PH_TYPE : PH_HUNT;
            PH_TYPE:    phase_in = PH_ID;
            PH_ID:      phase_in = PH_ADDR_HI;
            PH_ADDR_HI: phase_in = PH_ADDR_LO;
            PH_ADDR_LO: phase_in = PH_RETRY;
            PH_RETRY:   phase_in = PH_DELIV;
            PH_DELIV:   phase_in = PH_DISC;
            PH_DISC:    phase_in = PH_CSUM;
            PH_CSUM:    phase_in = PH_HUNT;
            default:    phase_in = (rx_byte == START_DELIM) ? PH_LEN_HI : PH_HUNT;
         endcase
      end
   end

   // outputs
   always_comb begin
      data_phase   = phase_ff inside {[PH_TYPE:PH_DISC]};
      result_valid = byte_valid && (phase_ff == PH_CSUM);
      len_zero_in  = len_zero_ff;
      sum_in       = sum_ff;
      if (byte_valid && phase_ff == PH_LEN_HI) begin
         len_zero_in = (rx_byte == 8'h00);
      end
      if (byte_valid && phase_ff == PH_LEN_LO) begin
         sum_in = 8'h00;
      end else if (byte_valid && data_phase) begin
         sum_in = sum_ff + rx_byte;
      end
      result.frame_type   = type_ff;
      result.frame_id     = id_ff;
      result.net_address  = addr_ff;
      result.retry_count  = retry_ff;
      result.deliv_status = deliv_ff;
      result.disc_status  = disc_ff;
      result.checksum_ok  = (~sum_ff == rx_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         len_zero_ff <= 1'b0;
         sum_ff      <= 8'h00;
      end else begin
         phase_ff    <= phase_in;
         len_zero_ff <= len_zero_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) begin
         case (phase_ff)
            PH_TYPE:    type_ff       <= rx_byte;
            PH_ID:      id_ff         <= rx_byte;
            PH_ADDR_HI: addr_ff[15:8] <= rx_byte;
            PH_ADDR_LO: addr_ff[7:0]  <= rx_byte;
            PH_RETRY:   retry_ff      <= rx_byte;
            PH_DELIV:   deliv_ff      <= rx_byte;
            PH_DISC:    disc_ff       <= rx_byte;
            default:    ;
         endcase
      end
   end

endmodule

// ----- rtl/core/apts_out_buf.sv -----
// Result output register with one skid entry.
module apts_out_buf
   import apts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  result_type     push_data,
   input  logic           out_stall,
   output result_type     out_data,
   output buf_status_type status
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_free;

   always_comb begin
      out_free      = !out_valid_ff || !out_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_data          = out_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

// ----- rtl/core/api_transmit_status_frame_parser.sv -----
// Top level of the API transmit status frame parser.
//
//   channel  direction  handshake             content
//   req      in         req_valid/req_stall   one received byte per transaction
//   rsp      out        rsp_valid/rsp_stall   one parsed frame per transaction
//
// One byte can be taken every cycle while req_stall is low; the phase counter advances once per byte.
// A result is registered on rsp once its checksum byte is taken, via the skid entry if rsp stalls.
// Synchronous reset returns the parser to hunting and empties the output.
// req_stall rises only when the output register and skid entry both hold results.
`include "api_transmit_status_frame_parser_assert.svh"
module api_transmit_status_frame_parser
   import apts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_frame_id,
   output logic [15:0] rsp_net_address,
   output logic [7:0]  rsp_retry_count,
   output logic [7:0]  rsp_deliv_status,
   output logic [7:0]  rsp_disc_status,
   output logic        rsp_checksum_ok
);

   logic           req_take;
   logic           res_valid;
   result_type     res_data;
   result_type     out_data;
   buf_status_type buf_status;

   assign req_take = req_valid && !req_stall;

   apts_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_take),
      .rx_byte      (req_rx_byte),
      .result_valid (res_valid),
      .result       (res_data)
   );

   apts_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .out_stall (rsp_stall),
      .out_data  (out_data),
      .status    (buf_status)
   );

   assign req_stall        = buf_status.skid_valid;
   assign rsp_valid        = buf_status.out_valid;
   assign rsp_frame_type   = out_data.frame_type;
   assign rsp_frame_id     = out_data.frame_id;
   assign rsp_net_address  = out_data.net_address;
   assign rsp_retry_count  = out_data.retry_count;
   assign rsp_deliv_status = out_data.deliv_status;
   assign rsp_disc_status  = out_data.disc_status;
   assign rsp_checksum_ok  = out_data.checksum_ok;

   `APTS_ASSERT_NOW(a_skid_needs_out, buf_status.skid_valid, buf_status.out_valid,
      "skid entry held while output register empty")
   `APTS_ASSERT_NOW(a_result_on_take, res_valid, req_take,
      "result produced without an accepted transaction")
   `APTS_ASSERT_NEXT(a_result_reaches_out, res_valid && !buf_status.out_valid,
      buf_status.out_valid, "result lost on empty output")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the API transmit status frame parser.
`timescale 1ns / 100ps

module testbench;
   import apts_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_type;
   logic [7:0]  rsp_frame_id;
   logic [15:0] rsp_net_address;
   logic [7:0]  rsp_retry_count;
   logic [7:0]  rsp_deliv_status;
   logic [7:0]  rsp_disc_status;
   logic        rsp_checksum_ok;

   // parser state as predicted
   phase_type   phase = PH_HUNT;
   logic        len_hi_zero = 1'b0;
   logic [7:0]  run_sum = 8'h00;
   result_type  held_frame = '0;

   result_type  pending_frames[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          sender_gaps = 1'b1;
   bit          sink_gaps = 1'b1;

   api_transmit_status_frame_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_net_address  (rsp_net_address),
      .rsp_retry_count  (rsp_retry_count),
      .rsp_deliv_status (rsp_deliv_status),
      .rsp_disc_status  (rsp_disc_status),
      .rsp_checksum_ok  (rsp_checksum_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("api_transmit_status_frame_parser test failed");
         $finish;
      end
   end

   // advance the parser by one accepted byte
   task automatic parse_byte(input logic [7:0] b);
      case (phase)
         PH_LEN_HI: begin
            len_hi_zero = (b == 8'h00);
            phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (len_hi_zero && b == FRAME_LEN) begin
               run_sum = 8'h00;
               phase = PH_TYPE;
            end else begin
               phase = PH_HUNT;
            end
         end
         PH_TYPE, PH_ID, PH_ADDR_HI, PH_ADDR_LO, PH_RETRY, PH_DELIV, PH_DISC: begin
            case (phase)
               PH_TYPE:    held_frame.frame_type = b;
               PH_ID:      held_frame.frame_id = b;
               PH_ADDR_HI: held_frame.net_address[15:8] = b;
               PH_ADDR_LO: held_frame.net_address[7:0] = b;
               PH_RETRY:   held_frame.retry_count = b;
               PH_DELIV:   held_frame.deliv_status = b;
               default:    held_frame.disc_status = b;
            endcase
            run_sum = run_sum + b;
            phase = phase_type'(phase + 4'd1);
         end
         PH_CSUM: begin
            held_frame.checksum_ok = ((8'hFF - run_sum) == b);
            pending_frames.push_back(held_frame);
            phase = PH_HUNT;
         end
         default: begin
            phase = (b == START_DELIM) ? PH_LEN_HI : PH_HUNT;
         end
      endcase
   endtask

   // entered and left at a falling edge; valid stays high on return
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      parse_byte(b);
      @(negedge clock);
   endtask

   function automatic logic [7:0] frame_checksum(input logic [55:0] payload);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 0; i < 7; i++) sum = sum + payload[i*8 +: 8];
      return 8'hFF - sum;
   endfunction

   // payload bytes go out most significant first
   task automatic send_frame(input logic [55:0] payload, input logic [7:0] csum);
      send_byte(START_DELIM);
      send_byte(8'h00);
      send_byte(FRAME_LEN);
      for (int i = 6; i >= 0; i--) send_byte(payload[i*8 +: 8]);
      send_byte(csum);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_frames.size() != 0);
   endtask

   task automatic test_rejected_length();
      send_byte(START_DELIM);
      send_byte(START_DELIM);
      send_byte(FRAME_LEN);
      send_byte(START_DELIM);
      send_byte(8'h00);
      send_byte(8'h08);
   endtask

   task automatic test_delimiter_in_frame();
      send_frame(56'hFFFF_FFFF_FFFF_7E, START_DELIM);
   endtask

   task automatic test_zero_frame();
      send_frame(56'h0, 8'hFF);
   endtask

   task automatic test_random_traffic(input int n_frames, input bit gaps_in,
                                      input bit gaps_out);
      int         sel;
      int         frames;
      logic [55:0] payload;
      logic [7:0] hi;
      logic [7:0] lo;
      sender_gaps = gaps_in;
      sink_gaps = gaps_out;
      frames = 0;
      while (frames < n_frames) begin
         sel = $urandom_range(0, 9);
         payload = 56'({$urandom, $urandom});
         if (sel <= 6) begin
            send_frame(payload, frame_checksum(payload));
            frames++;
         end else if (sel == 7) begin
            send_frame(payload, 8'($urandom_range(0, 255)));
            frames++;
         end else if (sel == 8) begin
            if ($urandom_range(0, 1)) begin
               hi = 8'h00;
               lo = 8'($urandom_range(0, 255));
               if (lo == FRAME_LEN) lo = 8'h00;
            end else begin
               hi = 8'($urandom_range(1, 255));
               lo = FRAME_LEN;
            end
            send_byte(START_DELIM);
            send_byte(hi);
            send_byte(lo);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // result sink: before each transaction, optionally hold rsp_stall high
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         hold = sink_gaps ? $urandom_range(0, 3) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || !rsp_valid);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_frame_type, rsp_frame_id, rsp_net_address, rsp_retry_count,
                rsp_deliv_status, rsp_disc_status, rsp_checksum_ok};
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected transaction: type=%h id=%h addr=%h", got.frame_type,
                        got.frame_id, got.net_address);
         end else begin
            want = pending_frames.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("mismatch exp: type=%h id=%h addr=%h retry=%h dlv=%h disc=%h ok=%b",
                           want.frame_type, want.frame_id, want.net_address,
                           want.retry_count, want.deliv_status,
                           want.disc_status, want.checksum_ok);
                  $display("         got: type=%h id=%h addr=%h retry=%h dlv=%h disc=%h ok=%b",
                           got.frame_type, got.frame_id, got.net_address,
                           got.retry_count, got.deliv_status,
                           got.disc_status, got.checksum_ok);
               end
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_rejected_length();
      test_delimiter_in_frame();
      test_zero_frame();
      drain_results();

      test_random_traffic(35, 1'b1, 1'b1);
      drain_results();
      test_random_traffic(35, 1'b0, 1'b0);
      test_random_traffic(35, 1'b1, 1'b0);
      drain_results();
      test_random_traffic(35, 1'b0, 1'b1);
      drain_results();

      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("api_transmit_status_frame_parser test passed");
      end else begin
         $display("api_transmit_status_frame_parser test failed");
      end
      $finish;
   end

endmodule

// ----- api_transmit_status_frame_parser.f -----
+incdir+rtl/core
rtl/core/apts_pkg.sv
rtl/core/apts_parse.sv
rtl/core/apts_out_buf.sv
rtl/core/api_transmit_status_frame_parser.sv
sim/testbench.sv
